// ===== hw/rtl/vadi_pkg.sv =====
package vadi_pkg;

    localparam int ATTR_DEPTH   = 4096;
    localparam int UNIQUE_DEPTH = 4096;
    localparam int ATTR_AW      = $clog2(ATTR_DEPTH);
    localparam int UNIQUE_AW    = $clog2(UNIQUE_DEPTH);
    localparam int ATTR_CW      = ATTR_AW + 1;
    localparam int UNIQUE_CW    = UNIQUE_AW + 1;
    localparam int IDX_W        = 16;
    localparam int SLOT_W       = 12;
    localparam int REC_WORDS    = 8;
    localparam int REC_W        = 32 * REC_WORDS;
    localparam int S_DATA_W     = 152;
    localparam int M_DATA_W     = 272;
    localparam int M_USER_W     = 3;

    localparam logic [1:0] FUNC_POS    = 2'd0;
    localparam logic [1:0] FUNC_NRM    = 2'd1;
    localparam logic [1:0] FUNC_TEX    = 2'd2;
    localparam logic [1:0] FUNC_CORNER = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                 load;
        logic                 append;
        logic                 gather;
        logic                 scan_start;
        logic                 scan_step;
        logic                 commit;
        logic                 out_load;
        logic [1:0]           out_status;
        logic                 out_new;
        logic                 out_use_rec;
        logic                 out_use_hit;
    } vadi_cmd_t;

    typedef struct packed {
        logic                 attr_full;
        logic                 idx_ok;
        logic                 scan_match;
        logic                 scan_last;
        logic                 scan_empty;
        logic                 uniq_full;
    } vadi_sts_t;

endpackage

// ===== hw/rtl/vadi_datapath.sv =====
module vadi_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vadi_pkg::vadi_cmd_t           cmd,
    output vadi_pkg::vadi_sts_t           sts,
    input  logic [vadi_pkg::S_DATA_W-1:0] in_data,
    input  logic [1:0]                    in_func,
    output logic [vadi_pkg::M_DATA_W-1:0] out_data,
    output logic [vadi_pkg::M_USER_W-1:0] out_user
);

    logic [95:0] pos_mem [vadi_pkg::ATTR_DEPTH];
    logic [95:0] nrm_mem [vadi_pkg::ATTR_DEPTH];
    logic [63:0] tex_mem [vadi_pkg::ATTR_DEPTH];
    logic [vadi_pkg::REC_W-1:0] uniq_mem [vadi_pkg::UNIQUE_DEPTH];

    logic [vadi_pkg::ATTR_CW-1:0]   pos_cnt_reg, nrm_cnt_reg, tex_cnt_reg;
    logic [vadi_pkg::UNIQUE_CW-1:0] uniq_cnt_reg;

    logic [1:0]                   func_reg;
    logic [95:0]                  words_reg;
    logic [vadi_pkg::IDX_W-1:0]   pi_reg, ti_reg, ni_reg;
    logic [95:0]                  pos_rd_reg, nrm_rd_reg;
    logic [63:0]                  tex_rd_reg;
    logic [vadi_pkg::REC_W-1:0]   uniq_rd_reg;
    logic [vadi_pkg::UNIQUE_CW-1:0] scan_ptr_reg, hit_reg;
    logic [vadi_pkg::REC_W-1:0]   rec;
    logic [vadi_pkg::ATTR_CW-1:0] sel_cnt;
    logic                         pos_ok, tex_ok, nrm_ok;
    logic [vadi_pkg::SLOT_W-1:0]  slot_val;

    assign rec = {tex_rd_reg, nrm_rd_reg, pos_rd_reg};

    always_comb begin
        case (func_reg)
            vadi_pkg::FUNC_POS: sel_cnt = pos_cnt_reg;
            vadi_pkg::FUNC_NRM: sel_cnt = nrm_cnt_reg;
            default:            sel_cnt = tex_cnt_reg;
        endcase
    end

    assign pos_ok = (pi_reg != '0) && ({1'b0, pi_reg} <= 17'(pos_cnt_reg));
    assign tex_ok = (ti_reg != '0) && ({1'b0, ti_reg} <= 17'(tex_cnt_reg));
    assign nrm_ok = (ni_reg != '0) && ({1'b0, ni_reg} <= 17'(nrm_cnt_reg));

    assign sts.attr_full  = sel_cnt == vadi_pkg::ATTR_CW'(vadi_pkg::ATTR_DEPTH);
    assign sts.idx_ok     = pos_ok && tex_ok && nrm_ok;
    assign sts.scan_match = uniq_rd_reg == rec;
    assign sts.scan_last  = scan_ptr_reg == uniq_cnt_reg;
    assign sts.scan_empty = uniq_cnt_reg == '0;
    assign sts.uniq_full  = uniq_cnt_reg == vadi_pkg::UNIQUE_CW'(vadi_pkg::UNIQUE_DEPTH);

    // attribute stores: latch on load, append with the result, gather for corners
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= in_func;
            words_reg <= in_data[95:0];
            pi_reg    <= in_data[111:96];
            ti_reg    <= in_data[127:112];
            ni_reg    <= in_data[143:128];
        end
        if (cmd.append && func_reg == vadi_pkg::FUNC_POS) begin
            pos_mem[pos_cnt_reg[vadi_pkg::ATTR_AW-1:0]] <= words_reg;
        end
        if (cmd.append && func_reg == vadi_pkg::FUNC_NRM) begin
            nrm_mem[nrm_cnt_reg[vadi_pkg::ATTR_AW-1:0]] <= words_reg;
        end
        if (cmd.append && func_reg == vadi_pkg::FUNC_TEX) begin
            tex_mem[tex_cnt_reg[vadi_pkg::ATTR_AW-1:0]] <= words_reg[63:0];
        end
        if (cmd.gather) begin
            pos_rd_reg <= pos_mem[vadi_pkg::ATTR_AW'(pi_reg - 16'd1)];
            nrm_rd_reg <= nrm_mem[vadi_pkg::ATTR_AW'(ni_reg - 16'd1)];
            tex_rd_reg <= tex_mem[vadi_pkg::ATTR_AW'(ti_reg - 16'd1)];
        end
    end

    // unique table scan: read entry at ptr, compare next cycle
    always_ff @(posedge aclk) begin
        if (cmd.scan_start || cmd.scan_step) begin
            uniq_rd_reg <= uniq_mem[scan_ptr_reg[vadi_pkg::UNIQUE_AW-1:0]];
        end
        if (cmd.commit) begin
            uniq_mem[uniq_cnt_reg[vadi_pkg::UNIQUE_AW-1:0]] <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg  <= '0;
            nrm_cnt_reg  <= '0;
            tex_cnt_reg  <= '0;
            uniq_cnt_reg <= '0;
            scan_ptr_reg <= '0;
            hit_reg      <= '0;
        end else begin
            if (cmd.load) begin
                scan_ptr_reg <= '0;
            end
            if (cmd.append && func_reg == vadi_pkg::FUNC_POS) begin
                pos_cnt_reg <= pos_cnt_reg + 1'b1;
            end
            if (cmd.append && func_reg == vadi_pkg::FUNC_NRM) begin
                nrm_cnt_reg <= nrm_cnt_reg + 1'b1;
            end
            if (cmd.append && func_reg == vadi_pkg::FUNC_TEX) begin
                tex_cnt_reg <= tex_cnt_reg + 1'b1;
            end
            if (cmd.scan_start || cmd.scan_step) begin
                scan_ptr_reg <= scan_ptr_reg + 1'b1;
                hit_reg      <= scan_ptr_reg;
            end
            if (cmd.commit) begin
                uniq_cnt_reg <= uniq_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (cmd.out_use_hit) begin
            slot_val = vadi_pkg::SLOT_W'(hit_reg);
        end else if (func_reg == vadi_pkg::FUNC_CORNER) begin
            slot_val = vadi_pkg::SLOT_W'(uniq_cnt_reg);
        end else begin
            slot_val = vadi_pkg::SLOT_W'(sel_cnt);
        end
        if (cmd.out_status != vadi_pkg::ST_OK) begin
            slot_val = '0;
        end
    end

    // result register; slot for appends is count before increment
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_user <= {cmd.out_new, cmd.out_status};
            out_data <= {4'b0, (cmd.out_use_rec ? rec : {vadi_pkg::REC_W{1'b0}}), slot_val};
        end
    end

endmodule

// ===== hw/rtl/vadi_ctrl.sv =====
module vadi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic [1:0]          in_func,
    input  vadi_pkg::vadi_sts_t sts,
    output vadi_pkg::vadi_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_CHECK  = 6'b000100,
        S_GATHER = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && aresetn;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.load     = s_tready && s_tvalid;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (in_func == vadi_pkg::FUNC_CORNER) ? S_CHECK : S_APPEND;
                end
            end
            S_APPEND: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = sts.attr_full ? vadi_pkg::ST_FULL : vadi_pkg::ST_OK;
                    cmd.append     = !sts.attr_full;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CHECK: begin
                if (!sts.idx_ok) begin
                    if (out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = vadi_pkg::ST_RANGE;
                        m_valid_next   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.gather = 1'b1;
                    state_next = S_GATHER;
                end
            end
            S_GATHER: begin
                if (sts.scan_empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_match) begin
                    if (out_free) begin
                        cmd.out_load    = 1'b1;
                        cmd.out_use_rec = 1'b1;
                        cmd.out_use_hit = 1'b1;
                        m_valid_next    = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else if (sts.scan_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_use_rec = 1'b1;
                    m_valid_next    = 1'b1;
                    if (sts.uniq_full) begin
                        cmd.out_status = vadi_pkg::ST_FULL;
                    end else begin
                        cmd.out_new = 1'b1;
                        cmd.commit  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/vertex_attribute_dedup_indexer.sv =====
// channel | ports          | payload
// s_      | s_tdata[151:0] | word_a, word_b, word_c, pos_index, tex_index, nrm_index
//         | s_tuser[1:0]   | func
// m_      | m_tdata[271:0] | slot, out_px .. out_tv
//         | m_tuser[2:0]   | status, is_new
// Appends pass IDLE and APPEND, out-of-range corners IDLE and CHECK; other corners
// pass CHECK, GATHER, one SCAN step per unique entry compared, and DONE when none
// matches; the unique-table linear scan sets their time.
// Synchronous active-low reset clears counts, scan pointer and control state; stores are not cleared.
// A stalled result holds in the output register; the next request is taken but its result waits.
module vertex_attribute_dedup_indexer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,  // word_a, word_b, word_c, pos_index, tex_index, nrm_index
    input  logic [1:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [271:0] m_tdata,  // slot, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                                   // out_tu, out_tv
    output logic [2:0]   m_tuser   // status, is_new
);

    vadi_pkg::vadi_cmd_t cmd;
    vadi_pkg::vadi_sts_t sts;

    vadi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .in_func  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    vadi_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_tdata),
        .in_func  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule

// ===== tb/vertex_attribute_dedup_indexer_test.sv =====
`timescale 1ns / 100ps

module vertex_attribute_dedup_indexer_test;

    typedef struct {
        logic [1:0]   status;
        logic [11:0]  slot;
        logic         is_new;
        logic [255:0] rec;
    } vertex_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [271:0] m_tdata;
    logic [2:0]   m_tuser;

    // golden copy of the tables
    logic [95:0]  pos_mem [vadi_pkg::ATTR_DEPTH];
    logic [95:0]  nrm_mem [vadi_pkg::ATTR_DEPTH];
    logic [63:0]  tex_mem [vadi_pkg::ATTR_DEPTH];
    int           pos_cnt, nrm_cnt, tex_cnt;
    logic [255:0] vertex_q [$];

    vertex_result_t pending_results [$];
    int errors, requests_sent, results_seen, hits_seen, fresh_seen, range_seen, full_seen;
    int burst_left, gap_max, hold_cycles, idle_cycles;
    bit rx_random;

    vertex_attribute_dedup_indexer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic predict_request(input logic [1:0] func, input logic [31:0] wa,
                                   input logic [31:0] wb, input logic [31:0] wc,
                                   input int pi, input int ti, input int ni);
        vertex_result_t r;
        int j;
        r.status = vadi_pkg::ST_OK;
        r.slot = '0;
        r.is_new = 1'b0;
        r.rec = '0;
        if (func == vadi_pkg::FUNC_POS || func == vadi_pkg::FUNC_NRM) begin
            if ((func == vadi_pkg::FUNC_POS ? pos_cnt : nrm_cnt) >= vadi_pkg::ATTR_DEPTH) begin
                r.status = vadi_pkg::ST_FULL;
            end else if (func == vadi_pkg::FUNC_POS) begin
                pos_mem[pos_cnt] = {wc, wb, wa};
                r.slot = pos_cnt[11:0];
                pos_cnt++;
            end else begin
                nrm_mem[nrm_cnt] = {wc, wb, wa};
                r.slot = nrm_cnt[11:0];
                nrm_cnt++;
            end
        end else if (func == vadi_pkg::FUNC_TEX) begin
            if (tex_cnt >= vadi_pkg::ATTR_DEPTH) begin
                r.status = vadi_pkg::ST_FULL;
            end else begin
                tex_mem[tex_cnt] = {wb, wa};
                r.slot = tex_cnt[11:0];
                tex_cnt++;
            end
        end else if (pi == 0 || pi > pos_cnt || ti == 0 || ti > tex_cnt ||
                     ni == 0 || ni > nrm_cnt) begin
            r.status = vadi_pkg::ST_RANGE;
            range_seen++;
        end else begin
            r.rec = {tex_mem[ti-1], nrm_mem[ni-1], pos_mem[pi-1]};
            r.is_new = 1'b1;
            for (j = 0; j < vertex_q.size(); j++) begin
                if (vertex_q[j] == r.rec) begin
                    r.slot = j[11:0];
                    r.is_new = 1'b0;
                    break;
                end
            end
            if (r.is_new) begin
                if (vertex_q.size() >= vadi_pkg::UNIQUE_DEPTH) begin
                    r.status = vadi_pkg::ST_FULL;
                    r.is_new = 1'b0;
                end else begin
                    r.slot = 12'(vertex_q.size());
                    vertex_q.push_back(r.rec);
                    fresh_seen++;
                end
            end else begin
                hits_seen++;
            end
        end
        if (r.status == vadi_pkg::ST_FULL) full_seen++;
        pending_results.push_back(r);
    endtask

    task automatic send_request(input logic [1:0] func, input logic [31:0] wa,
                                input logic [31:0] wb, input logic [31:0] wc,
                                input int pi, input int ti, input int ni);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {8'h00, ni[15:0], ti[15:0], pi[15:0], wc, wb, wa};
        do @(posedge aclk); while (!s_tready);
        predict_request(func, wa, wb, wc, pi, ti, ni);
        requests_sent++;
        burst_left--;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h3F80_0000;
            3: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // corner with every index in range when valid is set, else random indices
    task automatic send_corner(input bit valid);
        if (valid) begin
            send_request(vadi_pkg::FUNC_CORNER, $urandom(), $urandom(), $urandom(),
                         $urandom_range(1, pos_cnt), $urandom_range(1, tex_cnt),
                         $urandom_range(1, nrm_cnt));
        end else begin
            send_request(vadi_pkg::FUNC_CORNER, $urandom(), $urandom(), $urandom(),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
        end
    endtask

    task automatic test_directed();
        gap_max = 2;
        rx_random = 1'b0;
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 1, 1);
        send_request(vadi_pkg::FUNC_POS, 32'h0, 32'h0, 32'h0, 0, 0, 0);
        send_request(vadi_pkg::FUNC_POS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     65535, 65535, 65535);
        send_request(vadi_pkg::FUNC_POS, 32'h0, 32'h0, 32'h0, 0, 0, 0);
        send_request(vadi_pkg::FUNC_NRM, 32'h3F80_0000, 32'h0, 32'h8000_0000, 0, 0, 0);
        send_request(vadi_pkg::FUNC_NRM, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
        send_request(vadi_pkg::FUNC_TEX, 32'h0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 0, 0, 0);
        send_request(vadi_pkg::FUNC_TEX, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 0, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 0, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 1, 0);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 4, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 3, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 1, 3);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 65535, 65535, 65535);
        send_request(vadi_pkg::FUNC_CORNER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     1, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 3, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 2, 2, 2);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 2, 1, 2);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 2, 2, 2);
        wait_all_results();
    endtask

    task automatic test_random_mesh();
        int k, sel;
        gap_max = 4;
        rx_random = 1'b1;
        for (k = 0; k < 94; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 2)       send_request(vadi_pkg::FUNC_POS, pick_word(), pick_word(),
                                            pick_word(), $urandom_range(0, 65535), 0, 0);
            else if (sel < 4)  send_request(vadi_pkg::FUNC_NRM, pick_word(), pick_word(),
                                            pick_word(), 0, $urandom_range(0, 65535), 0);
            else if (sel < 5)  send_request(vadi_pkg::FUNC_TEX, pick_word(), pick_word(),
                                            pick_word(), 0, 0, $urandom_range(0, 65535));
            else if (sel < 7)  send_corner(1'b0);
            else               send_corner(1'b1);
        end
        wait_all_results();
    endtask

    task automatic test_backpressure();
        int k;
        gap_max = 0;
        rx_random = 1'b0;
        hold_cycles = 400;
        for (k = 0; k < 12; k++) send_corner(k % 4 != 0);
        wait_all_results();
    endtask

    task automatic test_index_limits();
        int k;
        gap_max = 3;
        rx_random = 1'b1;
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, pos_cnt, tex_cnt, nrm_cnt);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, pos_cnt + 1, 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, tex_cnt + 1, 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 1, 1, nrm_cnt + 1);
        send_request(vadi_pkg::FUNC_CORNER, '0, '0, '0, 65535, 65535, 65535);
        for (k = 0; k < 8; k++) send_corner(1'b1);
        wait_all_results();
    endtask

    // result checker
    always @(posedge aclk) begin
        vertex_result_t r;
        int k;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result tuser=%h tdata=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                r = pending_results.pop_front();
                if (m_tuser[1:0] !== r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, r.status, m_tuser[1:0]);
                    errors++;
                end
                if (m_tdata[11:0] !== r.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, r.slot, m_tdata[11:0]);
                    errors++;
                end
                if (m_tuser[2] !== r.is_new) begin
                    $display("%0t: is_new expected %0b actual %0b", $time, r.is_new, m_tuser[2]);
                    errors++;
                end
                for (k = 0; k < vadi_pkg::REC_WORDS; k++) begin
                    if (m_tdata[12 + 32*k +: 32] !== r.rec[32*k +: 32]) begin
                        $display("%0t: record word %0d expected %h actual %h", $time, k,
                                 r.rec[32*k +: 32], m_tdata[12 + 32*k +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall pattern
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_random) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 30000) begin
            $display("timeout: no request or result moved");
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = vadi_pkg::FUNC_POS;
        idle_cycles = 0;
        hold_cycles = 0;
        rx_random = 1'b0;
        burst_left = 0;
        gap_max = 0;
        pos_cnt = 0;
        nrm_cnt = 0;
        tex_cnt = 0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        fresh_seen = 0;
        range_seen = 0;
        full_seen = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_mesh();
        test_backpressure();
        test_index_limits();
        $display("%0d requests, %0d results: %0d new vertices, %0d reused, %0d range errors",
                 requests_sent, results_seen, fresh_seen, hits_seen, range_seen);
        $display("%0d full-table results; long output stall and drained pauses exercised",
                 full_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== vertex_attribute_dedup_indexer.f =====
hw/rtl/vadi_pkg.sv
hw/rtl/vadi_datapath.sv
hw/rtl/vadi_ctrl.sv
hw/rtl/vertex_attribute_dedup_indexer.sv
tb/vertex_attribute_dedup_indexer_test.sv
